// ===== src/compressor_plant_interlock_defines.svh =====
// Assertion macros for the compressor plant interlock.
`ifndef COMPRESSOR_PLANT_INTERLOCK_DEFINES_SVH
`define COMPRESSOR_PLANT_INTERLOCK_DEFINES_SVH
`ifndef SYNTHESIS
`define CPI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("interlock check failed");
`define CPI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("interlock sequence check failed");
`else
`define CPI_ASSERT(label, clk, rst, prop)
`define CPI_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== src/cpi_pkg.sv =====
// Types, codes and helpers for the compressor plant interlock.
`default_nettype none
package cpi_pkg;

   localparam int TEMP_W = 12;
   localparam int RH_W   = 10;

   typedef enum logic [2:0] {
      FUNC_TICK   = 3'd0,
      FUNC_TOGGLE = 3'd1,
      FUNC_PRESS1 = 3'd2,
      FUNC_PRESS2 = 3'd3,
      FUNC_HPS    = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_POWER     = 3'd1,
      ERR_EXPANSION = 3'd2,
      ERR_FIN       = 3'd3,
      ERR_HUMIDITY  = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      TANK_EMPTY   = 2'd0,
      TANK_FILLING = 2'd1,
      TANK_FULL    = 2'd2
   } tank_type;

   typedef enum logic [1:0] {
      FIN_NORMAL = 2'd0,
      FIN_ABOVE  = 2'd1,
      FIN_BELOW  = 2'd2
   } fin_type;

   typedef enum logic [3:0] {
      NOTE_NONE             = 4'd0,
      NOTE_START_POWER_FAIL = 4'd1,
      NOTE_START_FIN_LOW    = 4'd2,
      NOTE_STARTED          = 4'd3,
      NOTE_STOPPED          = 4'd4,
      NOTE_TRIP_POWER       = 4'd5,
      NOTE_TRIP_EXPANSION   = 4'd6,
      NOTE_TRIP_FIN         = 4'd7,
      NOTE_TRIP_HUMIDITY    = 4'd8,
      NOTE_EXPANSION_LOSS   = 4'd9
   } notice_type;

   // Output drive phases, one group per tick
   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_CT1  = 2'd1;
   localparam logic [1:0] PH_CT2  = 2'd2;
   localparam logic [1:0] PH_FAN  = 2'd3;

   typedef enum logic [1:0] {
      CSR_MIN_FIN   = 2'd0,
      CSR_UPPER_FIN = 2'd1,
      CSR_MIN_RH    = 2'd2
   } csr_type;

   function automatic fin_type fin_classify(input logic signed [TEMP_W-1:0] t,
                                            input logic signed [TEMP_W-1:0] lo,
                                            input logic signed [TEMP_W-1:0] hi);
      fin_type r;
      if (t >= lo && t <= hi) begin
         r = FIN_NORMAL;
      end else if (t > hi) begin
         r = FIN_ABOVE;
      end else begin
         r = FIN_BELOW;
      end
      return r;
   endfunction

   function automatic notice_type trip_notice(input err_type e);
      notice_type r;
      case (e)
         ERR_POWER:     r = NOTE_TRIP_POWER;
         ERR_EXPANSION: r = NOTE_TRIP_EXPANSION;
         ERR_FIN:       r = NOTE_TRIP_FIN;
         ERR_HUMIDITY:  r = NOTE_TRIP_HUMIDITY;
         default:       r = NOTE_NONE;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/compressor_plant_interlock.sv =====
// Top level of the compressor plant interlock: run control, fault checks, pin drive.
`default_nettype none
`include "compressor_plant_interlock_defines.svh"
// Each request word (tick, run toggle, pressure or high-pressure-switch event)
// returns one response word with the pin levels and status after that word.
// One word is taken every cycle unless the response stalls; a word lands in the input
// register, is evaluated against the plant state in one pass, and its response is
// written to the output register when the output advances. A stall holds the response
// register, then the full input register; the response register frees up the input
// side whenever it is empty or being taken. The user must write limits through the csr
// port only while the block is idle; the block does not enforce it. Limits take effect on the next word.
module compressor_plant_interlock (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_func,
   input  wire logic               req_power_good,
   input  wire logic               req_pressure_one,
   input  wire logic               req_pressure_two,
   input  wire logic               req_level_low_pin,
   input  wire logic               req_level_high_pin,
   input  wire logic               req_hps_pin,
   input  wire logic signed [11:0] req_fin1_temp,
   input  wire logic signed [11:0] req_fin2_temp,
   input  wire logic [9:0]         req_air_rh,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_ct1_drive,
   output logic                    rsp_ct2_drive,
   output logic                    rsp_fan_drive,
   output logic                    rsp_pump_drive,
   output logic                    rsp_running,
   output logic [2:0]              rsp_fault_code,
   output logic [1:0]              rsp_tank_status,
   output logic [1:0]              rsp_fin1_status,
   output logic [1:0]              rsp_fin2_status,
   output logic [3:0]              rsp_notice,
   input  wire logic               csr_write_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [11:0]        csr_wdata
);
   import cpi_pkg::*;

   // configuration
   logic signed [TEMP_W-1:0] min_fin_ff, upper_fin_ff;
   logic [RH_W-1:0]          min_rh_ff;

   // input register
   logic                     in_valid_ff;
   logic [2:0]               func_ff;
   logic                     pg_ff, p1_ff, p2_ff, lvl_lo_ff, lvl_hi_ff;
   logic signed [TEMP_W-1:0] t1_ff, t2_ff;
   logic [RH_W-1:0]          rh_ff;

   // plant state
   logic       run_ff, last_run_ff, cmd_ct1_ff, cmd_ct2_ff, cmd_fan_ff;
   logic       ct1_lvl_ff, ct2_lvl_ff, fan_lvl_ff, pump_lvl_ff, latch_ff;
   logic       exp1_ff, exp2_ff;
   tank_type   tank_ff;
   fin_type    fin1_ff, fin2_ff;
   err_type    err_ff;
   logic [1:0] phase_ff;

   // next state
   logic       run_in, last_run_in, cmd_ct1_in, cmd_ct2_in, cmd_fan_in;
   logic       ct1_lvl_in, ct2_lvl_in, fan_lvl_in, pump_lvl_in, latch_in;
   logic       exp1_in, exp2_in;
   tank_type   tank_in;
   fin_type    fin1_in, fin2_in;
   err_type    err_in;
   logic [1:0] phase_in;
   notice_type notice_in;

   // response register
   logic       out_valid_ff;
   logic       o_ct1_ff, o_ct2_ff, o_fan_ff, o_pump_ff, o_run_ff;
   err_type    o_err_ff;
   tank_type   o_tank_ff;
   fin_type    o_fin1_ff, o_fin2_ff;
   notice_type o_notice_ff;

   logic advance;
   logic fire;
   logic toggled;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign toggled   = !run_ff;

   always_comb begin
      run_in      = run_ff;
      last_run_in = last_run_ff;
      cmd_ct1_in  = cmd_ct1_ff;
      cmd_ct2_in  = cmd_ct2_ff;
      cmd_fan_in  = cmd_fan_ff;
      ct1_lvl_in  = ct1_lvl_ff;
      ct2_lvl_in  = ct2_lvl_ff;
      fan_lvl_in  = fan_lvl_ff;
      pump_lvl_in = pump_lvl_ff;
      latch_in    = latch_ff;
      exp1_in     = exp1_ff;
      exp2_in     = exp2_ff;
      tank_in     = tank_ff;
      fin1_in     = fin1_ff;
      fin2_in     = fin2_ff;
      err_in      = err_ff;
      phase_in    = phase_ff;
      notice_in   = NOTE_NONE;

      case (func_ff)
         FUNC_TICK: begin
            cmd_ct1_in = run_ff;
            cmd_ct2_in = run_ff;
            cmd_fan_in = run_ff;

            // level pins are active low
            if (lvl_lo_ff) begin
               tank_in = TANK_EMPTY;
            end else if (!lvl_hi_ff) begin
               tank_in = TANK_FULL;
            end else begin
               tank_in = TANK_FILLING;
            end

            fin1_in = fin_classify(t1_ff, min_fin_ff, upper_fin_ff);
            fin2_in = fin_classify(t2_ff, min_fin_ff, upper_fin_ff);
            exp1_in = p1_ff;
            exp2_in = p2_ff;

            if (!pg_ff) begin
               err_in = ERR_POWER;
            end else if (!(p1_ff && p2_ff)) begin
               err_in = ERR_EXPANSION;
            end else if (fin1_in != FIN_NORMAL || fin2_in != FIN_NORMAL) begin
               err_in = ERR_FIN;
            end else if (rh_ff < min_rh_ff) begin
               err_in = ERR_HUMIDITY;
            end else begin
               err_in = ERR_NONE;
            end

            // trip leaves last_run set on purpose
            if (err_in != ERR_NONE && run_ff) begin
               run_in    = 1'b0;
               notice_in = trip_notice(err_in);
            end

            if (pg_ff) begin
               if (phase_ff == PH_CT1) begin
                  ct1_lvl_in = run_ff;
               end else if (phase_ff == PH_CT2) begin
                  ct2_lvl_in = run_ff;
               end else if (phase_ff == PH_FAN) begin
                  fan_lvl_in = run_ff;
               end
            end else begin
               ct1_lvl_in = 1'b0;
               ct2_lvl_in = 1'b0;
               fan_lvl_in = 1'b0;
               cmd_ct1_in = 1'b0;
               cmd_ct2_in = 1'b0;
               cmd_fan_in = 1'b0;
            end

            if (tank_in == TANK_EMPTY) begin
               latch_in = 1'b0;
            end else if (tank_in == TANK_FULL) begin
               latch_in = 1'b1;
            end
            pump_lvl_in = latch_in;

            if (!p1_ff && !p2_ff && run_in && (last_run_ff == run_in)) begin
               run_in      = 1'b0;
               last_run_in = 1'b0;
               notice_in   = NOTE_EXPANSION_LOSS;
            end

            phase_in = phase_ff + 2'd1;
         end
         FUNC_TOGGLE: begin
            run_in = toggled;
            if (last_run_ff != toggled) begin
               if (toggled) begin
                  if (!pg_ff) begin
                     run_in     = 1'b0;
                     notice_in  = NOTE_START_POWER_FAIL;
                     cmd_ct1_in = 1'b0;
                     cmd_ct2_in = 1'b0;
                     cmd_fan_in = 1'b0;
                  end else if (t1_ff <= min_fin_ff || t2_ff <= min_fin_ff) begin
                     run_in    = 1'b0;
                     notice_in = NOTE_START_FIN_LOW;
                  end else begin
                     notice_in = NOTE_STARTED;
                  end
               end else begin
                  notice_in  = NOTE_STOPPED;
                  cmd_ct1_in = 1'b0;
                  cmd_ct2_in = 1'b0;
                  cmd_fan_in = 1'b0;
               end
               last_run_in = run_in;
            end else begin
               // resume after a trip: no checks, commands dropped
               cmd_ct1_in = 1'b0;
               cmd_ct2_in = 1'b0;
               cmd_fan_in = 1'b0;
            end
         end
         default: begin
            if (func_ff == FUNC_PRESS1) begin
               exp1_in    = p1_ff;
               ct1_lvl_in = 1'b0;
               cmd_ct1_in = 1'b0;
            end else if (func_ff == FUNC_PRESS2) begin
               exp2_in    = p2_ff;
               ct2_lvl_in = 1'b0;
               cmd_ct2_in = 1'b0;
            end else if (func_ff == FUNC_HPS) begin
               pump_lvl_in = 1'b0;
            end
            if (!cmd_ct1_in && !cmd_ct2_in) begin
               cmd_fan_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_fin_ff   <= 12'sd100;
         upper_fin_ff <= 12'sd400;
         min_rh_ff    <= 10'd400;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_FIN:   min_fin_ff   <= csr_wdata;
            CSR_UPPER_FIN: upper_fin_ff <= csr_wdata;
            CSR_MIN_RH:    min_rh_ff    <= csr_wdata[RH_W-1:0];
            default:       ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         func_ff   <= req_func;
         pg_ff     <= req_power_good;
         p1_ff     <= req_pressure_one;
         p2_ff     <= req_pressure_two;
         lvl_lo_ff <= req_level_low_pin;
         lvl_hi_ff <= req_level_high_pin;
         t1_ff     <= req_fin1_temp;
         t2_ff     <= req_fin2_temp;
         rh_ff     <= req_air_rh;
      end
   end

   // plant state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         last_run_ff  <= 1'b0;
         cmd_ct1_ff   <= 1'b0;
         cmd_ct2_ff   <= 1'b0;
         cmd_fan_ff   <= 1'b0;
         ct1_lvl_ff   <= 1'b0;
         ct2_lvl_ff   <= 1'b0;
         fan_lvl_ff   <= 1'b0;
         pump_lvl_ff  <= 1'b0;
         latch_ff     <= 1'b0;
         exp1_ff      <= 1'b0;
         exp2_ff      <= 1'b0;
         tank_ff      <= TANK_EMPTY;
         fin1_ff      <= FIN_NORMAL;
         fin2_ff      <= FIN_NORMAL;
         err_ff       <= ERR_NONE;
         phase_ff     <= PH_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            run_ff      <= run_in;
            last_run_ff <= last_run_in;
            cmd_ct1_ff  <= cmd_ct1_in;
            cmd_ct2_ff  <= cmd_ct2_in;
            cmd_fan_ff  <= cmd_fan_in;
            ct1_lvl_ff  <= ct1_lvl_in;
            ct2_lvl_ff  <= ct2_lvl_in;
            fan_lvl_ff  <= fan_lvl_in;
            pump_lvl_ff <= pump_lvl_in;
            latch_ff    <= latch_in;
            exp1_ff     <= exp1_in;
            exp2_ff     <= exp2_in;
            tank_ff     <= tank_in;
            fin1_ff     <= fin1_in;
            fin2_ff     <= fin2_in;
            err_ff      <= err_in;
            phase_ff    <= phase_in;
         end
      end
      if (fire) begin
         o_ct1_ff    <= ct1_lvl_in;
         o_ct2_ff    <= ct2_lvl_in;
         o_fan_ff    <= fan_lvl_in;
         o_pump_ff   <= pump_lvl_in;
         o_run_ff    <= run_in;
         o_err_ff    <= err_in;
         o_tank_ff   <= tank_in;
         o_fin1_ff   <= fin1_in;
         o_fin2_ff   <= fin2_in;
         o_notice_ff <= notice_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_ct1_drive   = o_ct1_ff;
   assign rsp_ct2_drive   = o_ct2_ff;
   assign rsp_fan_drive   = o_fan_ff;
   assign rsp_pump_drive  = o_pump_ff;
   assign rsp_running     = o_run_ff;
   assign rsp_fault_code  = o_err_ff;
   assign rsp_tank_status = o_tank_ff;
   assign rsp_fin1_status = o_fin1_ff;
   assign rsp_fin2_status = o_fin2_ff;
   assign rsp_notice      = o_notice_ff;

   `CPI_ASSERT(a_empty_out_takes_word, clock, reset, !out_valid_ff |-> req_ready)
   `CPI_ASSERT(a_started_is_running, clock, reset,
      (out_valid_ff && o_notice_ff == NOTE_STARTED) |-> o_run_ff)
   `CPI_ASSERT(a_trip_stops_with_error, clock, reset,
      (out_valid_ff && (o_notice_ff == NOTE_TRIP_POWER || o_notice_ff == NOTE_TRIP_EXPANSION
       || o_notice_ff == NOTE_TRIP_FIN || o_notice_ff == NOTE_TRIP_HUMIDITY))
      |-> (!o_run_ff && o_err_ff != ERR_NONE))
   `CPI_ASSERT_NEXT(a_tick_advances_phase, clock, reset,
      fire && func_ff == FUNC_TICK, phase_ff == $past(phase_ff) + 2'd1)
   `CPI_ASSERT_NEXT(a_idle_holds_state, clock, reset,
      !fire, $stable(run_ff) && $stable(phase_ff) && $stable(latch_ff))

endmodule
`default_nettype wire
